// ===== rtl/core/slot_allocator_with_fifo_wait_queue_defines.svh =====
// assertion macros for the slot allocator checker
// no dependencies; included by files that carry concurrent assertions
`ifndef SLOT_ALLOCATOR_WITH_FIFO_WAIT_QUEUE_DEFINES_SVH
`define SLOT_ALLOCATOR_WITH_FIFO_WAIT_QUEUE_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define SAWQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define SAWQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/sawq_pkg.sv =====
// shared types, widths and status codes of the slot allocator
// no dependencies
`default_nettype none

package sawq_pkg;

    localparam int DEF_MAX_SLOTS  = 16;
    localparam int DEF_WAIT_DEPTH = 16;
    localparam int INDEX_SPAN     = 16;

    localparam int CFG_W   = 5;
    localparam int IDX_W   = 4;
    localparam int ID_W    = 8;
    localparam int COUNT_W = 5;
    localparam int ST_W    = 3;

    localparam int S_DATA_W = 16;
    localparam int S_USER_W = 1;
    localparam int M_DATA_W = 24;
    localparam int M_USER_W = 3;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd10;

    localparam logic REQ_ARRIVAL = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    localparam logic [ST_W-1:0] ST_GRANTED   = 3'd0;
    localparam logic [ST_W-1:0] ST_QUEUED    = 3'd1;
    localparam logic [ST_W-1:0] ST_REJECTED  = 3'd2;
    localparam logic [ST_W-1:0] ST_FREED     = 3'd3;
    localparam logic [ST_W-1:0] ST_REGRANTED = 3'd4;
    localparam logic [ST_W-1:0] ST_BAD_INDEX = 3'd5;

    typedef struct packed {
        logic             set;
        logic             clr;
        logic [IDX_W-1:0] idx;
    } t_pool_cmd;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] free_idx;
        logic             idx_ok;
    } t_pool_stat;

    typedef struct packed {
        logic push;
        logic pop;
    } t_queue_cmd;

    typedef struct packed {
        logic            empty;
        logic            full;
        logic [ID_W-1:0] head_id;
    } t_queue_stat;

endpackage

`default_nettype wire

// ===== rtl/core/slot_allocator_with_fifo_wait_queue.sv =====
// First-free slot allocator with a FIFO wait queue. Each request transaction
// (arrival or release) yields exactly one result transaction. Throughput is one
// request per clock while m_tready does not stall the result; a request passes
// through the input register, the single decision stage (priority encode over
// the slot flags, one queue pointer move) and then the result register. The queue
// needs no clearing pass after reset. slots_in_use may be written at any time
// the block is idle and takes effect on the next request.
// depends on sawq_pkg, sawq_slot_pool, sawq_wait_queue
`default_nettype none

module slot_allocator_with_fifo_wait_queue
    import sawq_pkg::*;
#(
    parameter int MAX_SLOTS  = DEF_MAX_SLOTS,
    parameter int WAIT_DEPTH = DEF_WAIT_DEPTH
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [CFG_W-1:0]    i_cfg_wdata,
    input  wire logic                s_tvalid,
    output      logic                s_tready,
    // requester_id [7:0], slot_index [11:8], zero fill [15:12]
    input  wire logic [S_DATA_W-1:0] s_tdata,
    // req_type [0]
    input  wire logic [S_USER_W-1:0] s_tuser,
    output      logic                m_tvalid,
    input  wire logic                m_tready,
    // granted_slot [3:0], granted_id [11:4], waiting_count [16:12], zero fill [23:17]
    output      logic [M_DATA_W-1:0] m_tdata,
    // status [2:0]
    output      logic [M_USER_W-1:0] m_tuser
);

    localparam int FILL_W = $clog2(WAIT_DEPTH + 1);

    logic [CFG_W-1:0]  r_slots_in_use;

    logic              r_in_valid;
    logic              r_req_type;
    logic [ID_W-1:0]   r_req_id;
    logic [IDX_W-1:0]  r_req_idx;

    logic              r_out_valid;
    logic [ST_W-1:0]   r_status;
    logic [IDX_W-1:0]  r_slot;
    logic [ID_W-1:0]   r_id;
    logic [COUNT_W-1:0] r_count;

    logic              w_fire;
    t_pool_cmd         w_pool_cmd;
    t_pool_stat        w_pool_stat;
    t_queue_cmd        w_queue_cmd;
    t_queue_stat       w_queue_stat;
    logic [FILL_W-1:0] w_fill;

    logic [ST_W-1:0]   n_status;
    logic [IDX_W-1:0]  n_slot;
    logic [ID_W-1:0]   n_id;
    logic [FILL_W-1:0] n_fill;

    assign w_fire   = r_in_valid && (!r_out_valid || m_tready);
    assign s_tready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots_in_use <= CFG_RESET;
        end else if (i_cfg_we) begin
            r_slots_in_use <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_req_type <= s_tuser[0];
            r_req_id   <= s_tdata[7:0];
            r_req_idx  <= s_tdata[11:8];
        end
    end

    sawq_slot_pool #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_pool (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_slots_in_use (r_slots_in_use),
        .i_rel_idx      (r_req_idx),
        .i_cmd          (w_pool_cmd),
        .o_stat         (w_pool_stat)
    );

    sawq_wait_queue #(
        .WAIT_DEPTH (WAIT_DEPTH),
        .FILL_W     (FILL_W)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_queue_cmd),
        .i_push_id (r_req_id),
        .o_stat    (w_queue_stat),
        .o_fill    (w_fill)
    );

    always_comb begin
        w_pool_cmd  = '0;
        w_queue_cmd = '0;
        n_status    = ST_BAD_INDEX;
        n_slot      = '0;
        n_id        = '0;
        n_fill      = w_fill;
        if (r_req_type == REQ_ARRIVAL) begin
            n_id = r_req_id;
            if (w_queue_stat.empty && w_pool_stat.found) begin
                n_status       = ST_GRANTED;
                n_slot         = w_pool_stat.free_idx;
                w_pool_cmd.set = w_fire;
                w_pool_cmd.idx = w_pool_stat.free_idx;
            end else if (w_queue_stat.full) begin
                n_status = ST_REJECTED;
            end else begin
                n_status         = ST_QUEUED;
                w_queue_cmd.push = w_fire;
                n_fill           = w_fill + 1'b1;
            end
        end else begin
            n_slot         = r_req_idx;
            w_pool_cmd.idx = r_req_idx;
            if (!w_pool_stat.idx_ok) begin
                n_status = ST_BAD_INDEX;
            end else if (!w_queue_stat.empty) begin
                // head of the queue takes the released slot straight away
                n_status        = ST_REGRANTED;
                n_id            = w_queue_stat.head_id;
                w_pool_cmd.set  = w_fire;
                w_queue_cmd.pop = w_fire;
                n_fill          = w_fill - 1'b1;
            end else begin
                n_status       = ST_FREED;
                w_pool_cmd.clr = w_fire;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_status <= n_status;
            r_slot   <= n_slot;
            r_id     <= n_id;
            r_count  <= COUNT_W'(n_fill);
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tuser  = r_status;
    assign m_tdata  = {{(M_DATA_W - COUNT_W - ID_W - IDX_W){1'b0}}, r_count, r_id, r_slot};

endmodule

`default_nettype wire

// ===== rtl/core/sawq_slot_pool.sv =====
// slot busy flags and lowest-free-slot priority encoder
// depends on sawq_pkg
`default_nettype none

module sawq_slot_pool
    import sawq_pkg::*;
#(
    parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [CFG_W-1:0] i_slots_in_use,
    input  wire logic [IDX_W-1:0] i_rel_idx,
    input  wire t_pool_cmd        i_cmd,
    output      t_pool_stat       o_stat
);

    // only the first INDEX_SPAN slots are reachable by a 4-bit index
    localparam int NSLOT = (MAX_SLOTS < INDEX_SPAN) ? MAX_SLOTS : INDEX_SPAN;
    localparam logic [CFG_W-1:0] NSLOT_C = CFG_W'(NSLOT);

    logic [NSLOT-1:0] r_busy;
    logic [CFG_W-1:0] w_active;
    logic [NSLOT-1:0] w_avail;

    assign w_active = (i_slots_in_use > NSLOT_C) ? NSLOT_C : i_slots_in_use;

    always_comb begin
        for (int i = 0; i < NSLOT; i++) begin
            w_avail[i] = !r_busy[i] && (CFG_W'(i) < w_active);
        end
    end

    always_comb begin
        o_stat.found    = |w_avail;
        o_stat.free_idx = '0;
        // scan down so the lowest free slot wins
        for (int i = NSLOT - 1; i >= 0; i--) begin
            if (w_avail[i]) begin
                o_stat.free_idx = IDX_W'(i);
            end
        end
        o_stat.idx_ok = {1'b0, i_rel_idx} < w_active;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= '0;
        end else begin
            for (int i = 0; i < NSLOT; i++) begin
                if (i_cmd.set && i_cmd.idx == IDX_W'(i)) begin
                    r_busy[i] <= 1'b1;
                end else if (i_cmd.clr && i_cmd.idx == IDX_W'(i)) begin
                    r_busy[i] <= 1'b0;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sawq_wait_queue.sv =====
// circular fifo of waiting requester ids with a prefetched head entry
// depends on sawq_pkg
`default_nettype none

module sawq_wait_queue
    import sawq_pkg::*;
#(
    parameter int WAIT_DEPTH = DEF_WAIT_DEPTH,
    parameter int FILL_W     = $clog2(WAIT_DEPTH + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_queue_cmd        i_cmd,
    input  wire logic [ID_W-1:0]   i_push_id,
    output      t_queue_stat       o_stat,
    output      logic [FILL_W-1:0] o_fill
);

    localparam int AW = $clog2(WAIT_DEPTH);
    localparam logic [AW-1:0]     LAST_PTR = AW'(WAIT_DEPTH - 1);
    localparam logic [FILL_W-1:0] DEPTH_C  = FILL_W'(WAIT_DEPTH);

    logic [ID_W-1:0]   r_mem [WAIT_DEPTH];
    logic [AW-1:0]     r_head;
    logic [AW-1:0]     r_tail;
    logic [FILL_W-1:0] r_fill;
    logic [ID_W-1:0]   r_head_id;

    logic [AW-1:0]     n_head;
    logic [AW-1:0]     n_tail;
    logic [FILL_W-1:0] n_fill;

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_fill = r_fill;
        if (i_cmd.pop) begin
            n_head = (r_head == LAST_PTR) ? '0 : r_head + 1'b1;
            n_fill = r_fill - 1'b1;
        end else if (i_cmd.push) begin
            n_tail = (r_tail == LAST_PTR) ? '0 : r_tail + 1'b1;
            n_fill = r_fill + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_fill <= n_fill;
        end
    end

    // head entry is prefetched into a register from the next head pointer; a push into an empty queue bypasses
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[r_tail] <= i_push_id;
        end
        if (i_cmd.push && r_tail == n_head) begin
            r_head_id <= i_push_id;
        end else begin
            r_head_id <= r_mem[n_head];
        end
    end

    assign o_stat.empty   = (r_fill == '0);
    assign o_stat.full    = (r_fill >= DEPTH_C);
    assign o_stat.head_id = r_head_id;
    assign o_fill         = r_fill;

endmodule

`default_nettype wire

// ===== rtl/core/sawq_checker.sv =====
// port-level checks on the slot allocator result stream, bound to the top level
// depends on sawq_pkg and slot_allocator_with_fifo_wait_queue_defines.svh
`default_nettype none

`include "slot_allocator_with_fifo_wait_queue_defines.svh"

module sawq_checker
    import sawq_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [M_DATA_W-1:0] m_tdata,
    input wire logic [M_USER_W-1:0] m_tuser
);

    logic w_granted;
    logic w_no_slot;
    logic w_no_id;

    assign w_granted = m_tvalid && (m_tuser == ST_GRANTED);
    assign w_no_slot = m_tvalid && (m_tuser == ST_QUEUED || m_tuser == ST_REJECTED);
    assign w_no_id   = m_tvalid && (m_tuser == ST_FREED || m_tuser == ST_BAD_INDEX);

    `SAWQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // a direct grant only happens with nobody waiting
    `SAWQ_ASSERT_SAME(a_grant_empty, i_clk, i_rst_n, w_granted, m_tdata[16:12] == '0, "grant with waiting requesters")

    `SAWQ_ASSERT_SAME(a_queued_slot, i_clk, i_rst_n, w_no_slot, m_tdata[3:0] == '0, "slot reported on queued or rejected")

    `SAWQ_ASSERT_SAME(a_freed_id, i_clk, i_rst_n, w_no_id, m_tdata[11:4] == '0, "id reported on freed or bad index")

endmodule

bind slot_allocator_with_fifo_wait_queue sawq_checker u_sawq_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
